[rtl/l2c_pkg.sv]
// Shared types and constants for the L2TPv2 header classifier.
package l2c_pkg;

  localparam int unsigned PosW  = 17;
  localparam int unsigned HlenW = 17;
  localparam int unsigned WordW = 16;
  localparam int unsigned OfsW  = 4;

  localparam int unsigned FlagTBit = 7;
  localparam int unsigned FlagLBit = 6;
  localparam int unsigned FlagSBit = 3;
  localparam int unsigned FlagOBit = 1;

  localparam logic [OfsW-1:0]  BaseHdr     = 4'd6;
  localparam logic [3:0]       VersionL2tp = 4'd2;
  localparam logic [WordW-1:0] PppIp4      = 16'h0021;
  localparam logic [WordW-1:0] PppIp6      = 16'h0057;
  localparam logic [PosW-1:0]  PosMax      = '1;

  typedef enum logic [2:0] {
    VerdictIp4      = 3'd0,
    VerdictIp6      = 3'd1,
    VerdictPuntPpp  = 3'd2,
    VerdictPuntCtrl = 3'd3,
    VerdictDrop     = 3'd4,
    VerdictTrunc    = 3'd5,
    VerdictBadVer   = 3'd6
  } verdict_e;

  typedef enum logic [0:0] {
    RegPuntAvail = 1'b0
  } reg_idx_e;

  typedef struct packed {
    logic accept;
    logic first;
    logic last;
    logic punt_avail;
  } parse_ctl_t;

  typedef struct packed {
    verdict_e           verdict;
    logic [HlenW-1:0]   header_length;
    logic [WordW-1:0]   tunnel_key;
    logic [WordW-1:0]   session_key;
    logic [WordW-1:0]   ppp_protocol;
    logic [PosW-1:0]    packet_length;
  } result_t;

endpackage

[rtl/l2c_if.sv]
// Request and result channel interfaces of the L2TPv2 header classifier.
interface l2c_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       first_byte;
  logic       last_byte;

  modport source (output valid, data_byte, first_byte, last_byte, input ready);
  modport sink (input valid, data_byte, first_byte, last_byte, output ready);
endinterface

interface l2c_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  verdict;
  logic [16:0] header_length;
  logic [15:0] tunnel_key;
  logic [15:0] session_key;
  logic [15:0] ppp_protocol;
  logic [16:0] packet_length;

  modport source (output valid, verdict, header_length, tunnel_key, session_key,
                  ppp_protocol, packet_length, input ready);
  modport sink (input valid, verdict, header_length, tunnel_key, session_key,
                ppp_protocol, packet_length, output ready);
endinterface

[rtl/l2c_hdr_parser.sv]
// Per-packet header field capture and verdict logic.
module l2c_hdr_parser
  import l2c_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  parse_ctl_t ctl_i,
  input  logic [7:0] data_byte_i,
  output result_t    result_o
);

  logic [PosW-1:0]  pos_q, pos_d;
  logic [7:0]       flags_q, flags_d;
  logic [3:0]       ver_q, ver_d;
  logic [WordW-1:0] tunnel_q, tunnel_d;
  logic [WordW-1:0] session_q, session_d;
  logic [WordW-1:0] offset_q, offset_d;
  logic [HlenW-1:0] hlen_q, hlen_d;
  logic [WordW-1:0] proto_q, proto_d;

  logic             fresh;
  logic [PosW-1:0]  p;
  logic [7:0]       flags_b;
  logic [3:0]       ver_b;
  logic [WordW-1:0] tunnel_b, session_b, offset_b, proto_b;
  logic [HlenW-1:0] hlen_b;
  logic [OfsW-1:0]  idoff, ofs;
  logic [HlenW:0]   hlen_p2;
  logic [PosW-1:0]  len;

  always_comb begin
    fresh     = ctl_i.first || (pos_q == '0);
    p         = fresh ? '0 : pos_q;
    flags_b   = fresh ? '0 : flags_q;
    ver_b     = fresh ? '0 : ver_q;
    tunnel_b  = fresh ? '0 : tunnel_q;
    session_b = fresh ? '0 : session_q;
    offset_b  = fresh ? '0 : offset_q;
    hlen_b    = fresh ? '0 : hlen_q;
    proto_b   = fresh ? '0 : proto_q;

    flags_d = (p == '0) ? data_byte_i : flags_b;
    ver_d   = (p == PosW'(1)) ? data_byte_i[3:0] : ver_b;

    idoff = flags_d[FlagLBit] ? 4'd4 : 4'd2;
    ofs   = BaseHdr + (flags_d[FlagLBit] ? 4'd2 : 4'd0) + (flags_d[FlagSBit] ? 4'd4 : 4'd0);

    tunnel_d = tunnel_b;
    if (p == PosW'(idoff)) begin
      tunnel_d[15:8] = data_byte_i;
    end
    if (p == PosW'(idoff + 4'd1)) begin
      tunnel_d[7:0] = data_byte_i;
    end
    session_d = session_b;
    if (p == PosW'(idoff + 4'd2)) begin
      session_d[15:8] = data_byte_i;
    end
    if (p == PosW'(idoff + 4'd3)) begin
      session_d[7:0] = data_byte_i;
    end

    offset_d = offset_b;
    hlen_d   = hlen_b;
    if (p == '0) begin
      hlen_d = flags_d[FlagOBit] ? '0 : HlenW'(ofs);
    end
    if (flags_d[FlagOBit]) begin
      if (p == PosW'(ofs)) begin
        offset_d[15:8] = data_byte_i;
      end
      if (p == PosW'(ofs + 4'd1)) begin
        offset_d[7:0] = data_byte_i;
        hlen_d = HlenW'(ofs) + HlenW'(2) + HlenW'({offset_b[15:8], data_byte_i});
      end
    end

    // header length never matches the position in the cycle it is set
    proto_d = proto_b;
    if (hlen_b != '0) begin
      if (p == hlen_b) begin
        proto_d[15:8] = data_byte_i;
      end
      if (p == hlen_b + HlenW'(1)) begin
        proto_d[7:0] = data_byte_i;
      end
    end

    pos_d   = (p == PosMax) ? p : p + PosW'(1);
    len     = pos_d;
    hlen_p2 = {1'b0, hlen_d} + (HlenW+1)'(2);

    result_o.header_length = hlen_d;
    result_o.packet_length = len;
    result_o.tunnel_key    = (len >= PosW'(idoff + 4'd2)) ? tunnel_d : '0;
    result_o.session_key   = (len >= PosW'(idoff + 4'd4)) ? session_d : '0;
    result_o.ppp_protocol  = (hlen_d != '0 && {1'b0, len} >= hlen_p2) ? proto_d : '0;

    if (len < PosW'(BaseHdr)) begin
      result_o.verdict = VerdictTrunc;
    end else if (flags_d[FlagTBit]) begin
      result_o.verdict = ctl_i.punt_avail ? VerdictPuntCtrl : VerdictDrop;
    end else if (ver_d != VersionL2tp) begin
      result_o.verdict = VerdictBadVer;
    end else if (hlen_d == '0 || {1'b0, len} < hlen_p2) begin
      result_o.verdict = VerdictTrunc;
    end else if (proto_d == PppIp4) begin
      result_o.verdict = VerdictIp4;
    end else if (proto_d == PppIp6) begin
      result_o.verdict = VerdictIp6;
    end else begin
      result_o.verdict = ctl_i.punt_avail ? VerdictPuntPpp : VerdictDrop;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q     <= '0;
      flags_q   <= '0;
      ver_q     <= '0;
      tunnel_q  <= '0;
      session_q <= '0;
      offset_q  <= '0;
      hlen_q    <= '0;
      proto_q   <= '0;
    end else if (ctl_i.accept) begin
      if (ctl_i.last) begin
        pos_q     <= '0;
        flags_q   <= '0;
        ver_q     <= '0;
        tunnel_q  <= '0;
        session_q <= '0;
        offset_q  <= '0;
        hlen_q    <= '0;
        proto_q   <= '0;
      end else begin
        pos_q     <= pos_d;
        flags_q   <= flags_d;
        ver_q     <= ver_d;
        tunnel_q  <= tunnel_d;
        session_q <= session_d;
        offset_q  <= offset_d;
        hlen_q    <= hlen_d;
        proto_q   <= proto_d;
      end
    end
  end

endmodule

[rtl/l2tpv2_header_classifier.sv]
// Top level of the L2TPv2 header classifier.
//
// Usage:
//   in_i carries one packet byte per request, starting at the L2TP flags
//   byte, with first_byte and last_byte marks. A request is taken on any
//   clock with valid and ready high; one byte per cycle is sustained unless a held result stalls in_i.
//   out_o carries one result per packet, issued for the request that holds
//   last_byte. The result is registered and appears in the cycle after that
//   request is taken; all other requests give no result.
//   Throughput is one request per cycle, set by the single parse stage
//   feeding the result register. in_i.ready drops only while a result is
//   held and out_o.ready is low; the stalled result holds until taken.
//   The APB port has one register, punt_available, at byte address 0
//   (reads back its value, writes take effect at the access cycle).
//   Reset clears the packet state, empties the result register and sets
//   punt_available to 1.
module l2tpv2_header_classifier
  import l2c_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  l2c_in_if.sink      in_i,
  l2c_out_if.source   out_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic       punt_q;
  logic       out_valid_q, out_valid_d;
  result_t    res_q;
  result_t    res_d;
  parse_ctl_t ctl;
  logic       in_acc;
  reg_idx_e   reg_idx;

  assign reg_idx = reg_idx_e'(paddr[2]);
  assign pready  = 1'b1;

  always_comb begin
    prdata = '0;
    unique case (reg_idx)
      RegPuntAvail: prdata = {31'd0, punt_q};
      default:      prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      punt_q <= 1'b1;
    end else if (psel && penable && pwrite && pready && reg_idx == RegPuntAvail) begin
      punt_q <= pwdata[0];
    end
  end

  assign in_i.ready = !out_valid_q || out_o.ready;
  assign in_acc     = in_i.valid && in_i.ready;

  assign ctl.accept     = in_acc;
  assign ctl.first      = in_i.first_byte;
  assign ctl.last       = in_i.last_byte;
  assign ctl.punt_avail = punt_q;

  l2c_hdr_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctl_i       (ctl),
    .data_byte_i (in_i.data_byte),
    .result_o    (res_d)
  );

  always_comb begin
    out_valid_d = out_valid_q && !out_o.ready;
    if (in_acc && in_i.last_byte) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && in_i.last_byte) begin
      res_q <= res_d;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.verdict       = res_q.verdict;
  assign out_o.header_length = res_q.header_length;
  assign out_o.tunnel_key    = res_q.tunnel_key;
  assign out_o.session_key   = res_q.session_key;
  assign out_o.ppp_protocol  = res_q.ppp_protocol;
  assign out_o.packet_length = res_q.packet_length;

`ifndef ASSERT_OFF
  a_last_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && in_i.last_byte |=> out_o.valid)
    else $error("last byte taken without a result");

  a_result_has_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_o.valid) |-> $past(in_acc && in_i.last_byte))
    else $error("result without a last byte");

  a_verdict_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> out_o.verdict != 3'd7)
    else $error("undefined verdict code");

  a_ip_has_header: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && (out_o.verdict == VerdictIp4 || out_o.verdict == VerdictIp6) |->
      out_o.header_length != '0 &&
      {1'b0, out_o.packet_length} >= {1'b0, out_o.header_length} + 18'd2)
    else $error("data verdict on a short packet");

  a_length_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> out_o.packet_length != '0)
    else $error("result with zero packet length");
`endif

endmodule

[tb/l2tpv2_header_classifier_tb.sv]
// Randomized scoreboard testbench for the L2TPv2 header classifier.
module l2tpv2_header_classifier_tb;
  import l2c_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned StallLimit = 2000;
  localparam int unsigned ItemTarget = 1650;
  localparam int unsigned PhaseItems = (ItemTarget - 330) / 3;
  localparam logic [2:0] PuntAddr = 3'(4 * RegPuntAvail);

  class l2c_scoreboard;
    bit               punt_avail;
    logic [PosW-1:0]  pos;
    logic [7:0]       flags;
    logic [3:0]       ver;
    logic [15:0]      tun;
    logic [15:0]      ses;
    logic [15:0]      ofs;
    logic [HlenW-1:0] hlen;
    logic [15:0]      proto_w;
    result_t          expected_q[$];
    int unsigned      mismatches;

    function new();
      punt_avail = 1'b1;
      mismatches = 0;
      clear();
    endfunction

    function void clear();
      pos = '0;
      flags = '0;
      ver = '0;
      tun = '0;
      ses = '0;
      ofs = '0;
      hlen = '0;
      proto_w = '0;
    endfunction

    function int unsigned hdr_end();
      return int'(BaseHdr) + (flags[FlagLBit] ? 2 : 0) + (flags[FlagSBit] ? 4 : 0);
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    function void note_request(logic [7:0] b, logic first, logic last);
      int unsigned p, idoff, ofsp, hl, len;
      result_t exp;
      if (first) clear();
      p = pos;
      if (p == 0) begin
        clear();
        flags = b;
        if (!flags[FlagOBit]) hlen = HlenW'(hdr_end());
      end else if (p == 1) begin
        ver = b[3:0];
      end
      idoff = flags[FlagLBit] ? 4 : 2;
      ofsp = hdr_end();
      if (p == idoff) tun[15:8] = b;
      if (p == idoff + 1) tun[7:0] = b;
      if (p == idoff + 2) ses[15:8] = b;
      if (p == idoff + 3) ses[7:0] = b;
      if (flags[FlagOBit]) begin
        if (p == ofsp) ofs[15:8] = b;
        if (p == ofsp + 1) begin
          ofs[7:0] = b;
          hlen = HlenW'(ofsp + 2 + ofs);
        end
      end
      hl = hlen;
      if (hl != 0) begin
        if (p == hl) proto_w[15:8] = b;
        if (p == hl + 1) proto_w[7:0] = b;
      end
      if (pos != PosMax) pos = pos + 1'b1;
      len = pos;
      if (!last) return;

      exp.header_length = hlen;
      exp.tunnel_key = (len >= idoff + 2) ? tun : 16'h0;
      exp.session_key = (len >= idoff + 4) ? ses : 16'h0;
      exp.ppp_protocol = (hl != 0 && len >= hl + 2) ? proto_w : 16'h0;
      exp.packet_length = pos;
      if (len < int'(BaseHdr)) begin
        exp.verdict = VerdictTrunc;
      end else if (flags[FlagTBit]) begin
        if (punt_avail) exp.verdict = VerdictPuntCtrl;
        else exp.verdict = VerdictDrop;
      end else if (ver != VersionL2tp) begin
        exp.verdict = VerdictBadVer;
      end else if (hl == 0 || len < hl + 2) begin
        exp.verdict = VerdictTrunc;
      end else if (proto_w == PppIp4) begin
        exp.verdict = VerdictIp4;
      end else if (proto_w == PppIp6) begin
        exp.verdict = VerdictIp6;
      end else if (punt_avail) begin
        exp.verdict = VerdictPuntPpp;
      end else begin
        exp.verdict = VerdictDrop;
      end
      expected_q.push_back(exp);
      clear();
    endfunction

    function void check_result(result_t act);
      result_t exp;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: verdict %0d hlen %0d len %0d",
                   act.verdict, act.header_length, act.packet_length);
        return;
      end
      exp = expected_q.pop_front();
      if (act.verdict !== exp.verdict || act.header_length !== exp.header_length ||
          act.tunnel_key !== exp.tunnel_key || act.session_key !== exp.session_key ||
          act.ppp_protocol !== exp.ppp_protocol ||
          act.packet_length !== exp.packet_length) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"mismatch exp/act: verdict %0d/%0d hlen %0d/%0d tid %h/%h ",
                    "sid %h/%h ppp %h/%h len %0d/%0d"},
                   exp.verdict, act.verdict, exp.header_length, act.header_length,
                   exp.tunnel_key, act.tunnel_key, exp.session_key, act.session_key,
                   exp.ppp_protocol, act.ppp_protocol,
                   exp.packet_length, act.packet_length);
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  l2c_in_if  req_if ();
  l2c_out_if res_if ();

  l2c_scoreboard sb = new();
  bit            calm = 1'b0;
  int unsigned   bytes_sent = 0;
  int unsigned   packets_sent = 0;
  int unsigned   stall_cycles = 0;

  l2tpv2_header_classifier u_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (req_if),
    .out_o   (res_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  initial clk_i = 1'b0;
  always #1 clk_i = ~clk_i;

  always @(negedge clk_i) begin
    res_if.ready <= calm || ($urandom_range(99) >= 19);
  end

  always @(posedge clk_i) begin
    result_t act;
    if (rst_ni && res_if.valid && res_if.ready) begin
      act.verdict = verdict_e'(res_if.verdict);
      act.header_length = res_if.header_length;
      act.tunnel_key = res_if.tunnel_key;
      act.session_key = res_if.session_key;
      act.ppp_protocol = res_if.ppp_protocol;
      act.packet_length = res_if.packet_length;
      sb.check_result(act);
    end
  end

  always @(posedge clk_i) begin
    if ((req_if.valid && req_if.ready) || (res_if.valid && res_if.ready) || psel) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= StallLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic f, input logic l);
    @(negedge clk_i);
    while (!calm && $urandom_range(99) < 19) begin
      req_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    req_if.valid <= 1'b1;
    req_if.data_byte <= b;
    req_if.first_byte <= f;
    req_if.last_byte <= l;
    do @(posedge clk_i); while (req_if.ready !== 1'b1);
    sb.note_request(b, f, l);
    bytes_sent++;
  endtask

  task automatic send_seq(ref logic [7:0] q[$], input int unsigned n, input bit mark_first,
                          input bit end_mark);
    for (int unsigned i = 0; i < n; i++)
      send_byte(q[i], mark_first && i == 0, end_mark && i == n - 1);
    packets_sent++;
  endtask

  function automatic void build_packet(ref logic [7:0] q[$], input logic [7:0] flags,
                                       input logic [7:0] ver, input logic [15:0] tid,
                                       input logic [15:0] sid, input logic [15:0] ofs_size,
                                       input logic [15:0] proto, input int unsigned pay);
    q.delete();
    q.push_back(flags);
    q.push_back(ver);
    if (flags[FlagLBit]) repeat (2) q.push_back(8'($urandom));
    q.push_back(tid[15:8]);
    q.push_back(tid[7:0]);
    q.push_back(sid[15:8]);
    q.push_back(sid[7:0]);
    if (flags[FlagSBit]) repeat (4) q.push_back(8'($urandom));
    if (flags[FlagOBit]) begin
      q.push_back(ofs_size[15:8]);
      q.push_back(ofs_size[7:0]);
      repeat (ofs_size) q.push_back(8'($urandom));
    end
    q.push_back(proto[15:8]);
    q.push_back(proto[7:0]);
    repeat (pay) q.push_back(8'($urandom));
  endfunction

  task automatic drain();
    @(negedge clk_i);
    req_if.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
    @(negedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    if (addr == PuntAddr) sb.punt_avail = data[0];
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic random_packet();
    logic [7:0]  pkt[$];
    logic [7:0]  flags;
    logic [7:0]  ver;
    logic [15:0] proto;
    int unsigned kind, n;
    bit          mark_first;
    kind = $urandom_range(99);
    flags = 8'($urandom);
    flags[FlagTBit] = ($urandom_range(9) == 0);
    ver = 8'($urandom);
    if ($urandom_range(9) != 0) ver[3:0] = VersionL2tp;
    case ($urandom_range(3))
      0: proto = PppIp4;
      1: proto = PppIp6;
      2: proto = 16'($urandom);
      default: proto = PppIp4 ^ (16'h1 << $urandom_range(15));
    endcase
    build_packet(pkt, flags, ver, 16'($urandom), 16'($urandom), 16'($urandom_range(6)),
                 proto, $urandom_range(8));
    n = pkt.size();
    if ($urandom_range(6) == 0) n = $urandom_range(pkt.size(), 1);
    mark_first = ($urandom_range(9) != 0);
    if (kind < 70) begin
      send_seq(pkt, n, mark_first, 1'b1);
    end else if (kind < 85) begin
      pkt.delete();
      repeat ($urandom_range(12, 1)) pkt.push_back(8'($urandom));
      send_seq(pkt, pkt.size(), 1'($urandom_range(1)), 1'b1);
    end else begin
      send_seq(pkt, $urandom_range(pkt.size(), 1), mark_first, 1'b0);
      send_seq(pkt, pkt.size(), 1'b1, 1'b1);
    end
    if (packets_sent % 40 == 0) drain();
  endtask

  task automatic random_phase(input int unsigned count);
    int unsigned stop_at;
    stop_at = bytes_sent + count;
    while (bytes_sent < stop_at) random_packet();
  endtask

  initial begin
    logic [7:0] pkt[$];
    rst_ni = 1'b0;
    req_if.valid = 1'b0;
    req_if.data_byte = '0;
    req_if.first_byte = 1'b0;
    req_if.last_byte = 1'b0;
    res_if.ready = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    pkt = {8'hFF};
    send_seq(pkt, pkt.size(), 1'b1, 1'b1);
    pkt = {8'h80, 8'h02, 8'h12, 8'h34, 8'h56, 8'h78};
    send_seq(pkt, pkt.size(), 1'b1, 1'b1);
    pkt = {8'h00, 8'h03, 8'hFF, 8'hFF, 8'h00, 8'h00};
    send_seq(pkt, pkt.size(), 1'b1, 1'b1);
    pkt = {8'h00, 8'hF2, 8'hFF, 8'hFF, 8'h00, 8'h01, 8'h00, 8'h21};
    send_seq(pkt, pkt.size(), 1'b0, 1'b1);
    build_packet(pkt, 8'h02, 8'h02, 16'h0000, 16'hFFFF, 16'h0000, PppIp6, 0);
    send_seq(pkt, pkt.size(), 1'b1, 1'b1);
    drain();

    apb_write(PuntAddr, 32'd0);
    random_phase(PhaseItems);
    drain();

    apb_write(PuntAddr, 32'd1);
    calm = 1'b1;
    random_phase(PhaseItems);
    calm = 1'b0;
    build_packet(pkt, 8'h4A, 8'h02, 16'($urandom), 16'($urandom), 16'h0102, PppIp4, 4);
    send_seq(pkt, pkt.size(), 1'b1, 1'b1);
    build_packet(pkt, 8'h00, 8'h02, 16'($urandom), 16'($urandom), 16'h0000, PppIp6,
                 24);
    send_seq(pkt, pkt.size(), 1'b1, 1'b1);
    drain();

    apb_write(PuntAddr, 32'd0);
    random_phase(PhaseItems);
    drain();
    repeat (5) @(posedge clk_i);

    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
